### rtl/hmf_pkg.sv
// Package: shared constants for the HTTP message framer
`default_nettype none
package hmf_pkg;
    localparam int          COUNT_WIDTH_DEF = 32;
    localparam logic [31:0] SIZE_MAX_RESET  = 32'd270000000;
    localparam logic [31:0] CRLFCRLF        = 32'h0D0A0D0A;
    localparam logic [7:0]  CH_LF           = 8'h0A;
    localparam logic [7:0]  CH_COLON        = 8'h3A;
    localparam logic [7:0]  CH_SEMI         = 8'h3B;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_BODY    = 3'd1,
        PH_SIZE    = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAILER = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CL    = 2'd1,
        KIND_TE    = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef struct packed {
        logic start;
        logic first;
        logic name;
        logic value;
        logic started;
        logic failed;
    } line_flags_t;

    // Expected lowercase character of the name matcher at index i
    function automatic logic [7:0] name_char_at(input logic [4:0] i);
        case (i)
            5'd0:  name_char_at = "c";
            5'd1:  name_char_at = "o";
            5'd2:  name_char_at = "n";
            5'd3:  name_char_at = "t";
            5'd4:  name_char_at = "e";
            5'd5:  name_char_at = "n";
            5'd6:  name_char_at = "t";
            5'd7:  name_char_at = "-";
            5'd8:  name_char_at = "l";
            5'd9:  name_char_at = "e";
            5'd10: name_char_at = "n";
            5'd11: name_char_at = "g";
            5'd12: name_char_at = "t";
            5'd13: name_char_at = "h";
            5'd15: name_char_at = "r";
            5'd16: name_char_at = "a";
            5'd17: name_char_at = "n";
            5'd18: name_char_at = "s";
            5'd19: name_char_at = "f";
            5'd20: name_char_at = "e";
            5'd21: name_char_at = "r";
            5'd22: name_char_at = "-";
            5'd23: name_char_at = "e";
            5'd24: name_char_at = "n";
            5'd25: name_char_at = "c";
            5'd26: name_char_at = "o";
            5'd27: name_char_at = "d";
            5'd28: name_char_at = "i";
            5'd29: name_char_at = "n";
            5'd30: name_char_at = "g";
            default: name_char_at = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] chunk_char_at(input logic [2:0] i);
        case (i)
            3'd0: chunk_char_at = "c";
            3'd1: chunk_char_at = "h";
            3'd2: chunk_char_at = "u";
            3'd3: chunk_char_at = "n";
            3'd4: chunk_char_at = "k";
            3'd5: chunk_char_at = "e";
            3'd6: chunk_char_at = "d";
            default: chunk_char_at = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction
endpackage
`default_nettype wire

### rtl/hmf_accum.sv
// Saturating digit accumulator: v * radix + d with clamp at all ones
`default_nettype none
module hmf_accum #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic [COUNT_WIDTH-1:0] value,
    input  wire logic                   hex,
    input  wire logic [3:0]             digit,
    output logic      [COUNT_WIDTH-1:0] result
);
    logic [COUNT_WIDTH+3:0] wide;

    always_comb begin
        if (hex) begin
            wide = {value, 4'd0} + {{COUNT_WIDTH{1'b0}}, digit};
        end else begin
            wide = {3'd0, value, 1'b0} + {1'b0, value, 3'd0}
                 + {{COUNT_WIDTH{1'b0}}, digit};
        end
        result = (|wide[COUNT_WIDTH+3:COUNT_WIDTH]) ? '1 : wide[COUNT_WIDTH-1:0];
    end
endmodule
`default_nettype wire

### rtl/http_message_framer_unit.sv
// Top level: HTTP/1.x message framer, one stream byte per item
// Takes one byte per clock on s_ while m_ready does not stall the result, and
// returns one result item per byte on m_. A byte is held in an input register,
// and the whole per-byte state update runs between it and the result register.
// A result waiting on m_ready holds the byte in the input register. s_ready
// drops only while a byte is held and a result is waiting on m_ready.
`default_nettype none
module http_message_framer_unit #(
    parameter int COUNT_WIDTH = hmf_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_message_end,
    output logic [31:0]      m_message_bytes,
    output logic             m_overflow,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import hmf_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CONE = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CTWO = COUNT_WIDTH'(2);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic [31:0]      size_max_reg;
    phase_t           phase_reg, phase_next;
    logic [23:0]      tail_reg, tail_next;
    line_flags_t      lf_reg, lf_next;
    logic [4:0]       nidx_reg, nidx_next;
    kind_t            kind_reg, kind_next;
    logic [2:0]       cidx_reg, cidx_next;
    logic             pend_reg, pend_next;
    logic             chunked_reg, chunked_next;
    logic [COUNT_WIDTH-1:0] len_reg, len_next, rem_reg, rem_next, cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             end_next;
    logic [COUNT_WIDTH-1:0] acc_out;
    logic             acc_hex;
    logic [3:0]       acc_digit;

    logic             advance;
    logic             out_free;
    logic [7:0]       c, lc;
    logic [31:0]      window;
    logic             blank;

    assign out_free  = !m_valid || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign c         = in_byte_reg;
    assign lc        = to_lower(in_byte_reg);
    assign window    = {tail_reg, in_byte_reg};
    assign blank     = (in_byte_reg <= 8'h20);

    hmf_accum #(.COUNT_WIDTH(COUNT_WIDTH)) u_accum (
        .value (len_reg),
        .hex   (acc_hex),
        .digit (acc_digit),
        .result(acc_out)
    );

    always_comb begin
        acc_hex   = (phase_reg == PH_SIZE);
        acc_digit = 4'd0;
        if (c >= "0" && c <= "9") begin
            acc_digit = c[3:0];
        end else begin
            acc_digit = lc[3:0] + 4'd9;
        end
    end

    always_comb begin
        logic       do_value;
        logic       do_name;
        logic       nok;
        logic [4:0] ni;
        logic [COUNT_WIDTH-1:0] cnt_inc;
        do_value = 1'b0;
        do_name  = 1'b0;
        nok      = 1'b0;
        ni       = nidx_reg;
        phase_next   = phase_reg;
        lf_next      = lf_reg;
        nidx_next    = nidx_reg;
        kind_next    = kind_reg;
        cidx_next    = cidx_reg;
        pend_next    = pend_reg;
        chunked_next = chunked_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        end_next     = 1'b0;
        cnt_inc   = (cnt_reg == CMAX) ? cnt_reg : cnt_reg + CONE;
        cnt_next  = cnt_inc;
        tail_next = window[23:0];

        case (phase_reg)
            PH_HEADER: begin
                if (c == CH_LF) begin
                    lf_next   = '{start: 1'b1, default: 1'b0};
                    pend_next = 1'b0;
                    nidx_next = 5'd0;
                end else if (!lf_reg.first) begin
                    if (lf_reg.start) begin
                        pend_next = 1'b0;
                        nidx_next = 5'd0;
                        ni        = 5'd0;
                        if (blank) begin
                            lf_next  = '{value: 1'b1, default: 1'b0};
                        end else begin
                            lf_next  = '{name: 1'b1, default: 1'b0};
                            do_name  = 1'b1;
                        end
                    end else if (lf_reg.name) begin
                        do_name = 1'b1;
                    end else begin
                        do_value = 1'b1;
                    end
                end
                if (do_name) begin
                    if (c == CH_COLON) begin
                        if (!lf_next.failed && ni == 5'd14) begin
                            kind_next = KIND_CL;
                            len_next  = '0;
                        end else if (!lf_next.failed && ni == 5'd31) begin
                            kind_next    = KIND_TE;
                            cidx_next    = 3'd0;
                            chunked_next = 1'b0;
                        end else begin
                            kind_next = KIND_OTHER;
                        end
                        lf_next   = '{value: 1'b1, default: 1'b0};
                        pend_next = 1'b0;
                    end else if (!lf_next.failed) begin
                        if (blank) begin
                            pend_next = 1'b1;
                        end else begin
                            if (!pend_next) begin
                                if (ni == 5'd0) begin
                                    if (lc == "c") begin
                                        ni = 5'd1; nok = 1'b1;
                                    end else if (lc == "t") begin
                                        ni = 5'd15; nok = 1'b1;
                                    end
                                end else if ((ni < 5'd14 || (ni > 5'd14 && ni < 5'd31))
                                             && lc == name_char_at(ni)) begin
                                    ni = ni + 5'd1; nok = 1'b1;
                                end
                            end
                            if (nok) nidx_next = ni;
                            else lf_next.failed = 1'b1;
                        end
                    end
                end
                if (do_value) begin
                    if (blank) begin
                        if (lf_reg.started) pend_next = 1'b1;
                    end else begin
                        if (pend_reg && kind_reg == KIND_TE && cidx_reg != 3'd7)
                            cidx_next = 3'd0;
                        pend_next       = 1'b0;
                        lf_next.started = 1'b1;
                        if (kind_reg == KIND_CL && c >= "0" && c <= "9") begin
                            len_next = acc_out;
                        end else if (kind_reg == KIND_TE && cidx_next != 3'd7) begin
                            if (lc == chunk_char_at(cidx_next))
                                cidx_next = cidx_next + 3'd1;
                            else
                                cidx_next = (lc == "c") ? 3'd1 : 3'd0;
                            if (cidx_next == 3'd7) chunked_next = 1'b1;
                        end
                    end
                end
                if (window == CRLFCRLF) begin
                    if (chunked_next) begin
                        phase_next = PH_SIZE;
                        len_next   = '0;
                        pend_next  = 1'b0;
                    end else if (len_next == '0) begin
                        end_next = 1'b1;
                    end else begin
                        rem_next   = len_next;
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (rem_reg != '0) rem_next = rem_reg - CONE;
                if (rem_next == '0) end_next = 1'b1;
            end
            PH_SIZE: begin
                if (c == CH_LF) begin
                    if (len_reg == '0) begin
                        phase_next = PH_TRAILER;
                        tail_next  = {8'd0, window[15:0]};
                    end else begin
                        rem_next   = (len_reg >= CMAX - CONE) ? CMAX : len_reg + CTWO;
                        phase_next = PH_DATA;
                    end
                end else if (c == CH_SEMI) begin
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    if ((c >= "0" && c <= "9") || (lc >= "a" && lc <= "f"))
                        len_next = acc_out;
                end
            end
            PH_DATA: begin
                if (rem_reg != '0) rem_next = rem_reg - CONE;
                if (rem_next == '0) begin
                    phase_next = PH_SIZE;
                    len_next   = '0;
                    pend_next  = 1'b0;
                end
            end
            PH_TRAILER: begin
                if (window == CRLFCRLF) end_next = 1'b1;
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        ovf_next = ovf_reg;
        if (!end_next && (64'(cnt_inc) > 64'(size_max_reg)))
            ovf_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid      <= 1'b0;
            size_max_reg <= SIZE_MAX_RESET;
            phase_reg    <= PH_HEADER;
            tail_reg     <= '0;
            lf_reg       <= '{start: 1'b1, first: 1'b1, default: 1'b0};
            nidx_reg     <= '0;
            kind_reg     <= KIND_NONE;
            cidx_reg     <= '0;
            pend_reg     <= 1'b0;
            chunked_reg  <= 1'b0;
            len_reg      <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            if (cfg_valid) size_max_reg <= cfg_data;
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_data_byte;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid         <= 1'b1;
                m_message_end   <= end_next;
                m_message_bytes <= (64'(cnt_next) > 64'hFFFFFFFF)
                                   ? 32'hFFFFFFFF : 32'(cnt_next);
                m_overflow      <= ovf_next;
                ovf_reg         <= ovf_next;
                if (end_next) begin
                    phase_reg   <= PH_HEADER;
                    tail_reg    <= '0;
                    lf_reg      <= '{start: 1'b1, first: 1'b1, default: 1'b0};
                    nidx_reg    <= '0;
                    kind_reg    <= KIND_NONE;
                    cidx_reg    <= '0;
                    pend_reg    <= 1'b0;
                    chunked_reg <= 1'b0;
                    len_reg     <= '0;
                    rem_reg     <= '0;
                    cnt_reg     <= '0;
                end else begin
                    phase_reg   <= phase_next;
                    tail_reg    <= tail_next;
                    lf_reg      <= lf_next;
                    nidx_reg    <= nidx_next;
                    kind_reg    <= kind_next;
                    cidx_reg    <= cidx_next;
                    pend_reg    <= pend_next;
                    chunked_reg <= chunked_next;
                    len_reg     <= len_next;
                    rem_reg     <= rem_next;
                    cnt_reg     <= cnt_next;
                end
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg) else $error("overflow flag dropped");
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && end_next) |=> (cnt_reg == '0 && phase_reg == PH_HEADER))
        else $error("state not cleared after message end");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_message_end)
            && $stable(m_message_bytes) && $stable(m_overflow)))
        else $error("result item changed while waiting");
endmodule
`default_nettype wire

### verif/hmf_checker.sv
// Checker: watches the framer channels, predicts each result item and compares
module hmf_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_message_end,
    input  wire logic [31:0] m_message_bytes,
    input  wire logic        m_overflow,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending_count
);
    import hmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] CNT_ALL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        msg_end;
        logic [31:0] nbytes;
        logic        ovf;
    } frame_res_t;

    frame_res_t  expected_frames[$];

    logic [31:0] lim;
    phase_t      ph;
    logic [23:0] tail;
    line_flags_t lf;
    logic [4:0]  nidx;
    kind_t       kind;
    logic [2:0]  cidx;
    logic        spc;
    logic        chunked;
    logic [31:0] lenv;
    logic [31:0] remain;
    logic [31:0] cnt;
    logic        ovf_seen;

    function automatic logic [7:0] lc8(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [31:0] sat_acc(input logic [31:0] v, input logic [31:0] radix,
                                            input logic [31:0] d);
        if (v > (CNT_ALL - d) / radix) return CNT_ALL;
        return v * radix + d;
    endfunction

    function automatic logic [7:0] cl_at(input int i);
        string s;
        s = "content-length";
        return s[i];
    endfunction

    function automatic logic [7:0] te_at(input int i);
        string s;
        s = "transfer-encoding";
        return s[i];
    endfunction

    function automatic logic [7:0] ck_at(input int i);
        string s;
        s = "chunked";
        return s[i];
    endfunction

    task automatic clear_message();
        ph = PH_HEADER;
        tail = '0;
        lf = '0;
        lf.start = 1'b1;
        lf.first = 1'b1;
        nidx = '0;
        kind = KIND_NONE;
        cidx = '0;
        spc = 1'b0;
        chunked = 1'b0;
        lenv = '0;
        remain = '0;
        cnt = '0;
    endtask

    task automatic take_value(input logic [7:0] c);
        logic [7:0] l;
        if (c <= 8'h20) begin
            if (lf.started) spc = 1'b1;
            return;
        end
        if (spc && kind == KIND_TE && cidx != 3'd7) cidx = '0;
        spc = 1'b0;
        lf.started = 1'b1;
        if (kind == KIND_CL && c >= "0" && c <= "9") begin
            lenv = sat_acc(lenv, 10, {24'd0, c - 8'h30});
        end else if (kind == KIND_TE && cidx < 3'd7) begin
            l = lc8(c);
            if (l == ck_at(cidx)) cidx = cidx + 3'd1;
            else cidx = (l == "c") ? 3'd1 : 3'd0;
            if (cidx == 3'd7) chunked = 1'b1;
        end
    endtask

    task automatic take_name(input logic [7:0] c);
        logic [7:0] l;
        logic       ok;
        if (lf.failed) return;
        if (c <= 8'h20) begin
            spc = 1'b1;
            return;
        end
        l = lc8(c);
        ok = 1'b0;
        if (!spc) begin
            if (nidx == 0) begin
                if (l == "c") begin nidx = 5'd1; ok = 1'b1; end
                else if (l == "t") begin nidx = 5'd15; ok = 1'b1; end
            end else if (nidx < 14) begin
                if (l == cl_at(nidx)) begin nidx = nidx + 5'd1; ok = 1'b1; end
            end else if (nidx > 14 && nidx < 31) begin
                if (l == te_at(nidx - 14)) begin nidx = nidx + 5'd1; ok = 1'b1; end
            end
        end
        if (!ok) lf.failed = 1'b1;
    endtask

    task automatic take_header(input logic [7:0] c);
        if (c == CH_LF) begin
            lf = '0;
            lf.start = 1'b1;
            spc = 1'b0;
            nidx = '0;
            return;
        end
        if (lf.first) return;
        if (lf.start) begin
            spc = 1'b0;
            nidx = '0;
            if (c <= 8'h20) begin
                lf = '0;
                lf.value = 1'b1;
                take_value(c);
                return;
            end
            lf = '0;
            lf.name = 1'b1;
        end
        if (lf.name) begin
            if (c == CH_COLON) begin
                if (!lf.failed && nidx == 5'd14) begin
                    kind = KIND_CL;
                    lenv = '0;
                end else if (!lf.failed && nidx == 5'd31) begin
                    kind = KIND_TE;
                    cidx = '0;
                    chunked = 1'b0;
                end else begin
                    kind = KIND_OTHER;
                end
                lf = '0;
                lf.value = 1'b1;
                spc = 1'b0;
            end else begin
                take_name(c);
            end
        end else begin
            take_value(c);
        end
    endtask

    task automatic frame_byte(input logic [7:0] c);
        logic [31:0] win;
        logic        done;
        logic [7:0]  l;
        frame_res_t  r;
        done = 1'b0;
        if (cnt != CNT_ALL) cnt = cnt + 1;
        win = {tail, c};
        tail = win[23:0];
        case (ph)
            PH_HEADER: begin
                take_header(c);
                if (win == CRLFCRLF) begin
                    if (chunked) begin
                        ph = PH_SIZE;
                        lenv = '0;
                        spc = 1'b0;
                    end else if (lenv == 0) begin
                        done = 1'b1;
                    end else begin
                        remain = lenv;
                        ph = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (remain > 0) remain = remain - 1;
                if (remain == 0) done = 1'b1;
            end
            PH_SIZE: begin
                if (c == CH_LF) begin
                    if (lenv == 0) begin
                        ph = PH_TRAILER;
                        tail[23:16] = 8'h00;
                    end else begin
                        remain = (lenv > CNT_ALL - 2) ? CNT_ALL : lenv + 2;
                        ph = PH_DATA;
                    end
                end else if (c == CH_SEMI) begin
                    spc = 1'b1;
                end else if (!spc) begin
                    l = lc8(c);
                    if (c >= "0" && c <= "9")
                        lenv = sat_acc(lenv, 16, {24'd0, c - 8'h30});
                    else if (l >= "a" && l <= "f")
                        lenv = sat_acc(lenv, 16, {24'd0, l - 8'h57});
                end
            end
            PH_DATA: begin
                if (remain > 0) remain = remain - 1;
                if (remain == 0) begin
                    ph = PH_SIZE;
                    lenv = '0;
                    spc = 1'b0;
                end
            end
            PH_TRAILER: begin
                if (win == CRLFCRLF) done = 1'b1;
            end
            default: ph = PH_HEADER;
        endcase
        if (!done && cnt > lim) ovf_seen = 1'b1;
        r.msg_end = done;
        r.nbytes = cnt;
        r.ovf = ovf_seen;
        expected_frames.push_back(r);
        if (done) clear_message();
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending_count = expected_frames.size();

    initial begin
        fail_count = 0;
        lim = SIZE_MAX_RESET;
        ovf_seen = 1'b0;
        clear_message();
    end

    always @(posedge aclk) begin
        frame_res_t e;
        if (!aresetn) begin
            lim = SIZE_MAX_RESET;
            ovf_seen = 1'b0;
            clear_message();
            expected_frames.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    e = expected_frames.pop_front();
                    if (m_message_end !== e.msg_end)
                        report_mismatch($sformatf("message_end %0b exp %0b",
                                                  m_message_end, e.msg_end));
                    if (m_message_bytes !== e.nbytes)
                        report_mismatch($sformatf("message_bytes %0d exp %0d",
                                                  m_message_bytes, e.nbytes));
                    if (m_overflow !== e.ovf)
                        report_mismatch($sformatf("overflow %0b exp %0b",
                                                  m_overflow, e.ovf));
                end
            end
            if (s_valid && s_ready) frame_byte(s_data_byte);
            if (cfg_valid && cfg_ready) lim = cfg_data;
        end
    end
endmodule

### verif/tb_top.sv
// Testbench top: drives byte streams and size_max writes into the framer
module tb_top;
    import hmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_message_end;
    logic [31:0] m_message_bytes;
    logic        m_overflow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending_count;
    bit          calm;
    int          sent;

    http_message_framer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_message_end(m_message_end),
        .m_message_bytes(m_message_bytes), .m_overflow(m_overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    hmf_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_message_end(m_message_end),
        .m_message_bytes(m_message_bytes), .m_overflow(m_overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic write_size_max(input logic [31:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic string mix_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if ($urandom_range(0, 1))
                r[i] = (r[i] >= "a" && r[i] <= "z") ? byte'(r[i] - 32) : r[i];
        return r;
    endfunction

    task automatic send_message();
        int kind;
        int n;
        string ws;
        kind = $urandom_range(0, 9);
        ws = $urandom_range(0, 1) ? " " : "";
        send_text("GET / HTTP/1.1\r\n");
        if ($urandom_range(0, 2) == 0) send_text({"Host:", ws, "x\r\n"});
        if (kind < 4) begin
            n = $urandom_range(0, 12);
            send_text({mix_case("Content-Length"), ws, ": ", $sformatf("%0d", n), ws, "\r\n"});
            if ($urandom_range(0, 3) == 0) send_text(" 1\r\n");
            send_text("\r\n");
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 8) begin
            send_text({mix_case("Transfer-Encoding"), ":", ws, "gzip, ",
                       mix_case("chunked"), "\r\n\r\n"});
            repeat ($urandom_range(0, 3)) begin
                n = $urandom_range(1, 9);
                send_text($sformatf("%h", n[3:0]));
                if ($urandom_range(0, 1)) send_text(";ext=a");
                send_text("\r\n");
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                send_text("\r\n");
            end
            send_text("0\r\n");
            if ($urandom_range(0, 1)) send_text("X-T: 1\r\n");
            send_text("\r\n");
        end else if (kind == 8) begin
            send_text("\r\n");
        end else begin
            repeat ($urandom_range(1, 30))
                send_byte(8'($urandom_range(0, 1) ? $urandom_range(0, 255)
                             : 8'h0D + 8'h0D * $urandom_range(0, 1)
                               - 8'h03 * $urandom_range(0, 1)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        sent = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("X\r\n\r\n");
        send_text("P\r\nCONTENT-LENGTH : 3\r\n\r\n\x00\xff\x80");
        write_size_max(32'd1);
        send_text("P\r\nContent-Length: 2\r\nContent-Length: 1\r\n\r\nZ");
        send_text("P\r\nTransfer-Encoding: chun\r\n\tked\r\n\r\nA;x\r\n0123456789\r\n0\r\n\r\n");
        write_size_max(32'hFFFF_FFFF);
        send_text("P\r\nTransfer-Encoding: x chunked\r\nTransfer-Encoding: gzip\r\n\r\n");
        write_size_max(32'd0);
        send_text("\r\n\r\n");

        while (sent < 1800) begin
            if ($urandom_range(0, 60) == 0)
                write_size_max($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(10, 80));
            if (sent > 1500) calm = 1'b1;
            send_message();
        end
        write_size_max(SIZE_MAX_RESET);
        send_message();
        send_text("P\r\nContent-Length: 99999999999\r\n\r\n");
        send_text("P\r\ntransfer-encoding:CHUNKED\r\n\r\nFFFFFFFFFF\r\n");
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
